@@ rtl/egh_pkg.sv @@
package egh_pkg;

    // Field widths
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int DIV_W   = 15;

    // Default reset value of the compensation register
    localparam int INITIAL_COMPENSATION_DEFAULT = 0;

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_EDGE  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_TIMER = 2'd3
    } action_t;

    // Direction of the last accepted hole edge
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_TICKS     = 2'd1,
        CFG_NODE      = 2'd2
    } cfg_index_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } sts_t;

endpackage

@@ rtl/egh_divider.sv @@
module egh_divider
    import egh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   shifted;
    logic             ge;

    // One restoring step per cycle, dividend bits shift out as quotient bits shift in
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(shifted - {1'b0, dvs_reg}) : DIV_W'(shifted);
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // Last step lands on this edge
    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = quo_reg;

endmodule

@@ rtl/egh_ctrl.sv @@
module egh_ctrl
    import egh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // Hold until the previous result has left
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on commit, drop when taken
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/egh_datapath.sv @@
module egh_datapath
    import egh_pkg::*;
#(
    parameter int INITIAL_COMPENSATION = INITIAL_COMPENSATION_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic [63:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    output logic [31:0]      m_tdata,
    output logic [1:0]       m_tuser,
    input  cmd_t             cmd,
    output sts_t             sts
);

    // Configuration
    logic [DIV_W-1:0]   thr_reg;
    logic [DIV_W-1:0]   tph_reg;
    logic [CFG_W-1:0]   node_reg;

    // Captured item
    action_t            act_reg;
    logic [COUNT_W-1:0] enc_reg, target_reg, nh_reg, nd_reg;

    // Counter state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] diff_reg, diff_next;
    logic [COUNT_W-1:0] comp_reg, comp_next;
    logic [COUNT_W-1:0] last_enc_reg, last_enc_next;
    dir_t               dir_reg, dir_next;
    logic               report_reg, report_next;
    logic               restart_reg, restart_next;

    logic signed [COUNT_W-1:0] travel;
    logic signed [COUNT_W:0]   trav_x, thr_x;
    logic                      fwd, back, count_zero, div_used;
    logic [DIV_W-1:0]          quotient;
    logic [COUNT_W-1:0]        q_ext, comp_add, dec, c1, d1;
    logic                      div_done;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= DIV_W'(1);
            tph_reg  <= DIV_W'(1);
            node_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_wdata[DIV_W-1:0];
                CFG_TICKS:     tph_reg  <= cfg_wdata[DIV_W-1:0];
                CFG_NODE:      node_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= action_t'(s_tuser);
            enc_reg    <= s_tdata[15:0];
            target_reg <= s_tdata[31:16];
            nh_reg     <= s_tdata[47:32];
            nd_reg     <= s_tdata[63:48];
        end
    end

    // Classify the edge from travel since the last accepted hole edge or matching set
    always_comb
    begin
        travel     = $signed(enc_reg - last_enc_reg);
        trav_x     = {travel[COUNT_W-1], travel};
        thr_x      = $signed({2'b00, thr_reg});
        count_zero = (count_reg == '0);
        fwd        = (trav_x >= thr_x);
        back       = (trav_x <= -thr_x) && !count_zero;
        div_used   = !travel[COUNT_W-1] && (travel != '0) && (tph_reg != '0);
    end

    assign sts.need_div = (act_reg == ACT_EDGE) && fwd && count_zero && div_used;
    assign sts.div_done = div_done;

    egh_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (travel[DIV_W-1:0]),
        .divisor  (tph_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Compute the state after this item
    always_comb
    begin
        q_ext         = div_used ? COUNT_W'(quotient) : '0;
        comp_add      = count_zero ? q_ext : '0;
        dec           = (dir_reg == DIR_FWD) ? COUNT_W'(2) : COUNT_W'(1);
        c1            = count_reg - dec;
        d1            = diff_reg - dec;
        count_next    = count_reg;
        diff_next     = diff_reg;
        comp_next     = comp_reg;
        last_enc_next = last_enc_reg;
        dir_next      = dir_reg;
        restart_next  = 1'b0;
        case (act_reg)
            ACT_EDGE:
            begin
                if (fwd)
                begin
                    if (count_zero)
                    begin
                        comp_next = q_ext;
                    end
                    count_next    = count_reg + comp_add + COUNT_W'(1);
                    diff_next     = diff_reg + comp_add + COUNT_W'(1);
                    restart_next  = 1'b1;
                    last_enc_next = enc_reg;
                    dir_next      = DIR_FWD;
                end
                else if (back)
                begin
                    // Clear both counts once they fall to the compensation
                    if ($signed({1'b0, c1}) <= $signed({comp_reg[COUNT_W-1], comp_reg}))
                    begin
                        count_next = '0;
                        diff_next  = '0;
                    end
                    else
                    begin
                        count_next = c1;
                        diff_next  = d1;
                    end
                    restart_next  = 1'b1;
                    last_enc_next = enc_reg;
                    dir_next      = DIR_BACK;
                end
            end
            ACT_SET:
            begin
                if (target_reg == node_reg)
                begin
                    count_next    = nh_reg;
                    diff_next     = nd_reg;
                    last_enc_next = enc_reg;
                end
            end
            ACT_CLEAR:
            begin
                if (target_reg == node_reg)
                begin
                    diff_next = '0;
                end
            end
            ACT_TIMER:
            begin
                diff_next = '0;
            end
            default:
            begin
                diff_next = diff_reg;
            end
        endcase
        report_next = (act_reg == ACT_EDGE) && (diff_next != diff_reg);
    end

    // Commit state; counts double as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            diff_reg     <= '0;
            comp_reg     <= COUNT_W'(INITIAL_COMPENSATION);
            last_enc_reg <= '0;
            dir_reg      <= DIR_NONE;
            report_reg   <= 1'b0;
            restart_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            count_reg    <= count_next;
            diff_reg     <= diff_next;
            comp_reg     <= comp_next;
            last_enc_reg <= last_enc_next;
            dir_reg      <= dir_next;
            report_reg   <= report_next;
            restart_reg  <= restart_next;
        end
    end

    assign m_tdata = {diff_reg, count_reg};
    assign m_tuser = {restart_reg, report_reg};

endmodule

@@ rtl/encoder_gated_hole_counter_unit.sv @@
// Channel  Dir  tdata (low bit up)                                   tuser
// s_*      in   encoder_value, target_id, new_holes, new_diff (64)   action
// m_*      out  hole_total, hole_delta (32)                          report, restart_timer
// cfg_*    in   cfg_we, cfg_index, cfg_wdata: 0 threshold, 1 ticks per hole, 2 node address
//
// An item passes from acceptance through a calculate step to an update step that commits
// it and registers its result; a forward edge from zero that needs the compensation
// quotient adds a divide step in which the 15-bit restoring divider gives one bit a cycle.
// One item is in flight at a time; s_tready is high only while the controller idles.
// A result waiting on m_tready holds the next item in its update step.
// rst_n clears the counts and the direction, loads the initial compensation and
// returns the configuration to its defaults at once.
module encoder_gated_hole_counter_unit
    import egh_pkg::*;
#(
    parameter int INITIAL_COMPENSATION = INITIAL_COMPENSATION_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // encoder_value, target_id, new_holes, new_diff
    input  logic [1:0]       s_tuser,   // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // hole_total, hole_delta
    output logic [1:0]       m_tuser,   // report, restart_timer
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    egh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    egh_datapath #(
        .INITIAL_COMPENSATION (INITIAL_COMPENSATION)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ rtl/egh_checker.sv @@
module egh_checker
    import egh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A report only comes with a timer restart, from an accepted edge
    a_report_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("report without timer restart");

    // One item in flight: no acceptance right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // Input is ready in the same cycle that a result first appears, the controller being idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued while still busy");

endmodule

bind encoder_gated_hole_counter_unit egh_checker u_egh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/encoder_gated_hole_counter_unit_tb.sv @@
`timescale 1ns / 1ps

module encoder_gated_hole_counter_unit_tb
    import egh_pkg::*;
();

    // Expected status after one item
    typedef struct {
        logic        report;
        logic        restart;
        logic [15:0] total;
        logic [15:0] delta;
    } hole_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // Predicted counter state and register copies
    logic [15:0] cnt_holes;
    logic [15:0] cnt_diff;
    logic [15:0] cnt_comp;
    logic [15:0] cnt_last_enc;
    dir_t        cnt_dir;
    logic [14:0] reg_threshold;
    logic [14:0] reg_ticks;
    logic [15:0] reg_node;

    hole_status_t status_q[$];
    int          mismatch_count = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          holdoff_cycles = 0;

    encoder_gated_hole_counter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #5_000_000;
        $display("[encoder_gated_hole_counter_unit] ERROR");
        $finish;
    end

    // Return the counter state to its reset values
    function automatic void reset_counter_state();
        cnt_holes     = '0;
        cnt_diff      = '0;
        cnt_comp      = 16'(INITIAL_COMPENSATION_DEFAULT);
        cnt_last_enc  = '0;
        cnt_dir       = DIR_NONE;
        reg_threshold = 15'd1;
        reg_ticks     = 15'd1;
        reg_node      = '0;
    endfunction

    // Advance the counter state by one item and return the status it gives
    function automatic hole_status_t count_hole_item(action_t act, logic [15:0] enc,
                                                     logic [15:0] tgt, logic [15:0] nh,
                                                     logic [15:0] nd);
        hole_status_t       st;
        logic [15:0]        diff_before;
        logic signed [15:0] travel16;
        logic signed [15:0] comp16;
        int                 travel;
        int                 thr;
        int                 quot;
        int                 holes_i;
        int                 comp_i;

        st.report   = 1'b0;
        st.restart  = 1'b0;
        diff_before = cnt_diff;
        case (act)
            ACT_EDGE:
            begin
                travel16 = enc - cnt_last_enc;
                travel   = travel16;
                thr      = {17'd0, reg_threshold};
                if (travel >= thr)
                begin
                    // forward; from an empty count add the travel-based compensation
                    if (cnt_holes == 16'd0)
                    begin
                        quot = 0;
                        if (reg_ticks != 15'd0)
                            quot = travel / int'({17'd0, reg_ticks});
                        if (quot < 0)
                            quot = 0;
                        cnt_comp  = quot[15:0];
                        cnt_holes = cnt_holes + cnt_comp;
                        cnt_diff  = cnt_diff + cnt_comp;
                    end
                    cnt_holes    = cnt_holes + 16'd1;
                    cnt_diff     = cnt_diff + 16'd1;
                    st.restart   = 1'b1;
                    cnt_last_enc = enc;
                    cnt_dir      = DIR_FWD;
                end
                else if (travel <= -thr && cnt_holes != 16'd0)
                begin
                    // backward; drop one extra hole right after a forward move
                    if (cnt_dir == DIR_FWD)
                    begin
                        cnt_holes = cnt_holes - 16'd1;
                        cnt_diff  = cnt_diff - 16'd1;
                    end
                    cnt_holes  = cnt_holes - 16'd1;
                    cnt_diff   = cnt_diff - 16'd1;
                    st.restart = 1'b1;
                    holes_i    = {16'd0, cnt_holes};
                    comp16     = cnt_comp;
                    comp_i     = comp16;
                    if (holes_i <= comp_i)
                    begin
                        cnt_holes = '0;
                        cnt_diff  = '0;
                    end
                    cnt_last_enc = enc;
                    cnt_dir      = DIR_BACK;
                end
                st.report = (diff_before != cnt_diff);
            end
            ACT_SET:
            begin
                if (tgt == reg_node)
                begin
                    cnt_holes    = nh;
                    cnt_diff     = nd;
                    cnt_last_enc = enc;
                end
            end
            ACT_CLEAR:
            begin
                if (tgt == reg_node)
                    cnt_diff = '0;
            end
            default:
            begin
                cnt_diff = '0;
            end
        endcase
        st.total = cnt_holes;
        st.delta = cnt_diff;
        return st;
    endfunction

    // Offer one item, with random idle cycles ahead of it, and hold it until accepted
    task automatic send_item(action_t act, logic [15:0] enc, logic [15:0] tgt,
                             logic [15:0] nh, logic [15:0] nd);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {nd, nh, tgt, enc};
        do
            @(posedge clk);
        while (!s_tready);
        status_q.push_back(count_hole_item(act, enc, tgt, nh, nd));
    endtask

    // Drop valid and wait until every expected item has come out
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write one register; the block must be idle and the caller drops the enable
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD: reg_threshold = val[14:0];
            CFG_TICKS:     reg_ticks = val[14:0];
            default:       reg_node = val;
        endcase
    endtask

    task automatic load_registers(logic [14:0] thr, logic [14:0] ticks, logic [15:0] node);
        drain_block();
        write_reg(CFG_THRESHOLD, {1'b0, thr});
        write_reg(CFG_TICKS, {1'b0, ticks});
        write_reg(CFG_NODE, node);
        cfg_we <= 1'b0;
    endtask

    // Mostly edges with travel around the threshold, plus commands and timer expiries
    task automatic send_random_item();
        int          pick;
        int          delta;
        int          thr;
        int          ticks;
        logic [15:0] tgt;
        logic [15:0] nh;

        thr   = {17'd0, reg_threshold};
        ticks = {17'd0, reg_ticks};
        pick  = $urandom_range(99);
        tgt   = ($urandom_range(3) != 0) ? reg_node : 16'($urandom);
        if (pick < 62)
        begin
            case ($urandom_range(9))
                0, 1, 2: delta = thr + $urandom_range(0, 3 * ticks);
                3:       delta = thr + $urandom_range(0, 15);
                4, 5, 6: delta = -(thr + $urandom_range(0, 15));
                7:       delta = $urandom_range(1) ? thr - 1 : 1 - thr;
                8:       delta = $urandom;
                default: delta = 0;
            endcase
            send_item(ACT_EDGE, cnt_last_enc + delta[15:0], 16'($urandom),
                      16'($urandom), 16'($urandom));
        end
        else if (pick < 76)
        begin
            nh = $urandom_range(1) ? 16'($urandom_range(0, 8)) : 16'($urandom);
            send_item(ACT_SET, 16'($urandom), tgt, nh, 16'($urandom));
        end
        else if (pick < 90)
            send_item(ACT_CLEAR, 16'($urandom), tgt, 16'($urandom), 16'($urandom));
        else
            send_item(ACT_TIMER, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
    endtask

    task automatic run_random_items(int n);
        repeat (n) send_random_item();
    endtask

    // Edges from reset: ignored, forward from zero, backward clear, commands, wraps
    task automatic test_directed_defaults();
        gap_pct   = 0;
        stall_pct = 0;
        send_item(ACT_TIMER, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_EDGE, 16'hFFFB, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'd10, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'd20, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'd10, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_SET, 16'h0000, 16'h0000, 16'd100, 16'hFFFD);
        send_item(ACT_SET, 16'h1234, 16'h0001, 16'd7, 16'd7);
        send_item(ACT_CLEAR, 16'h0000, 16'h0005, 16'h0000, 16'h0000);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_SET, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000);
        send_item(ACT_EDGE, 16'h8001, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_TIMER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain_block();
    endtask

    // Zero threshold and zero divisor
    task automatic test_directed_zero_registers();
        load_registers(15'd0, 15'd0, 16'h00A5);
        send_item(ACT_SET, 16'h0000, 16'h00A5, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'hFFF0, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_SET, 16'h0000, 16'h00A5, 16'h0000, 16'h0003);
        send_item(ACT_EDGE, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        drain_block();
    endtask

    // All registers at their largest values
    task automatic test_directed_register_maximums();
        load_registers(15'h7FFF, 15'h7FFF, 16'hFFFF);
        send_item(ACT_SET, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_EDGE, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_SET, 16'h0000, 16'hFFFF, 16'd5, 16'd5);
        send_item(ACT_EDGE, 16'h8001, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_CLEAR, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        drain_block();
    endtask

    task automatic test_random_no_idle();
        gap_pct   = 0;
        stall_pct = 0;
        load_registers(15'd3, 15'd5, 16'($urandom));
        run_random_items(450);
        drain_block();
    endtask

    task automatic test_random_sender_idle();
        gap_pct   = 52;
        stall_pct = 0;
        load_registers(15'($urandom_range(1, 64)), 15'($urandom_range(1, 32)),
                       16'($urandom));
        run_random_items(450);
        drain_block();
    endtask

    task automatic test_random_receiver_stall();
        gap_pct   = 0;
        stall_pct = 52;
        load_registers(15'd1, 15'h7FFF, 16'hFFFF);
        run_random_items(225);
        load_registers(15'h7FFF, 15'd1, 16'h0000);
        run_random_items(225);
        drain_block();
    endtask

    task automatic test_random_both_idle();
        gap_pct   = 6;
        stall_pct = 6;
        load_registers(15'($urandom_range(0, 4)), 15'($urandom_range(0, 4)),
                       16'($urandom));
        run_random_items(450);
        drain_block();
    endtask

    // Hold off the receiver while items keep coming, so the input stalls
    task automatic test_output_holdoff();
        gap_pct        = 0;
        stall_pct      = 0;
        load_registers(15'd2, 15'd3, 16'h0042);
        holdoff_cycles = 400;
        run_random_items(60);
        drain_block();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            m_tready       <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        hole_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: total %h delta %h report %b restart %b",
                             m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1]);
                mismatch_count++;
            end
            else
            begin
                want = status_q.pop_front();
                if (m_tuser[0] !== want.report || m_tuser[1] !== want.restart ||
                    m_tdata[15:0] !== want.total || m_tdata[31:16] !== want.delta)
                begin
                    if (mismatch_count < 10)
                        $display({"mismatch: expected total %h delta %h report %b ",
                                  "restart %b, got total %h delta %h report %b restart %b"},
                                 want.total, want.delta, want.report, want.restart,
                                 m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        reset_counter_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_directed_zero_registers();
        test_directed_register_maximums();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_holdoff();
        drain_block();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && status_q.size() == 0)
            $display("[encoder_gated_hole_counter_unit] OK");
        else
            $display("[encoder_gated_hole_counter_unit] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/egh_pkg.sv
rtl/egh_divider.sv
rtl/egh_ctrl.sv
rtl/egh_datapath.sv
rtl/encoder_gated_hole_counter_unit.sv
rtl/egh_checker.sv
dv/encoder_gated_hole_counter_unit_tb.sv
